// ===== hdl/scts_pkg.sv =====
`default_nettype none
package scts_pkg;

    // angle reduction constants, Q16
    localparam int ANG_W = 21;
    localparam logic signed [ANG_W-1:0] Q_PI     = 21'sd205887;
    localparam logic signed [ANG_W-1:0] Q_TWO_PI = 21'sd411775;

    // series term datapath
    localparam int AX_W   = 18;
    localparam int X2_W   = 20;
    localparam int TERM_W = 24;
    localparam int RCP_SH = 24;
    localparam int DIV_W  = 6;

    // register stages ahead of the tangent divider
    localparam int NS = 12;

    localparam logic [TERM_W-1:0] RECIP_6  = TERM_W'((2**RCP_SH) / 6);
    localparam logic [TERM_W-1:0] RECIP_12 = TERM_W'((2**RCP_SH) / 12);
    localparam logic [TERM_W-1:0] RECIP_20 = TERM_W'((2**RCP_SH) / 20);
    localparam logic [TERM_W-1:0] RECIP_30 = TERM_W'((2**RCP_SH) / 30);
    localparam logic [TERM_W-1:0] RECIP_42 = TERM_W'((2**RCP_SH) / 42);
    localparam logic [DIV_W-1:0]  DIV_6    = 6'd6;
    localparam logic [DIV_W-1:0]  DIV_12   = 6'd12;
    localparam logic [DIV_W-1:0]  DIV_20   = 6'd20;
    localparam logic [DIV_W-1:0]  DIV_30   = 6'd30;
    localparam logic [DIV_W-1:0]  DIV_42   = 6'd42;

    // series result and divider widths
    localparam int SC_W    = 25;
    localparam int DEN_W   = SC_W - 1;
    localparam int NUM_W   = DEN_W + 16;
    localparam int VAL_W   = 32;

    localparam logic [1:0] MODE_COS = 2'd1;

    typedef struct packed {
        logic                    tan;
        logic signed [VAL_W-1:0] res;
        logic                    qneg;
        logic                    czero;
        logic                    sneg;
    } t_side;

endpackage
`default_nettype wire

// ===== hdl/scts_term.sv =====
`default_nettype none
module scts_term import scts_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [TERM_W-1:0] i_a,
    input  wire logic [X2_W-1:0]   i_x2,
    input  wire logic [TERM_W-1:0] i_recip,
    input  wire logic [DIV_W-1:0]  i_div,
    output logic      [TERM_W-1:0] o_f
);

    logic [TERM_W+X2_W-1:0]   prod;
    logic [2*TERM_W-1:0]      qprod;
    logic [TERM_W+DIV_W-1:0]  qd;
    logic [TERM_W-1:0]        rem;
    logic [TERM_W-1:0]        r_p;
    logic [TERM_W-1:0]        r_pb;
    logic [TERM_W-1:0]        r_q0;

    assign prod  = {{X2_W{1'b0}}, i_a} * {{TERM_W{1'b0}}, i_x2};
    assign qprod = {{TERM_W{1'b0}}, r_p} * {{TERM_W{1'b0}}, i_recip};
    assign qd    = {{DIV_W{1'b0}}, r_q0} * {{TERM_W{1'b0}}, i_div};
    // estimate is low by at most one
    assign rem   = r_pb - qd[TERM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= prod[TERM_W+15:16];
            r_q0 <= qprod[2*TERM_W-1:RCP_SH];
            r_pb <= r_p;
            o_f  <= (rem >= TERM_W'(i_div)) ? r_q0 + TERM_W'(1) : r_q0;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/scts_divider.sv =====
`default_nettype none
module scts_divider import scts_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire t_side            i_side,
    output logic                  o_valid,
    output logic      [NUM_W-1:0] o_quot,
    output t_side                 o_side
);

    logic [DEN_W-1:0] r_rem  [1:NUM_W];
    logic [NUM_W-1:0] r_num  [1:NUM_W];
    logic [DEN_W-1:0] r_den  [1:NUM_W];
    t_side            r_side [1:NUM_W];
    logic [NUM_W:1]   r_vld;

    logic [DEN_W-1:0] n_rem [1:NUM_W];
    logic [NUM_W-1:0] n_num [1:NUM_W];

    // one quotient bit per stage, msb first
    always_comb begin
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W:0]   diff;
        for (int k = 1; k <= NUM_W; k++) begin
            rem_in = (k == 1) ? '0 : r_rem[k-1];
            num_in = (k == 1) ? i_num : r_num[k-1];
            den_in = (k == 1) ? i_den : r_den[k-1];
            rem_sh = {rem_in, num_in[NUM_W-1]};
            diff   = rem_sh - {1'b0, den_in};
            if (rem_sh >= {1'b0, den_in}) begin
                n_rem[k] = diff[DEN_W-1:0];
                n_num[k] = {num_in[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = rem_sh[DEN_W-1:0];
                n_num[k] = {num_in[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[1]  <= i_den;
            r_side[1] <= i_side;
            for (int k = 2; k <= NUM_W; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 1; k <= NUM_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_num[NUM_W];
    assign o_side  = r_side[NUM_W];

endmodule
`default_nettype wire

// ===== hdl/sine_cosine_tangent_series.sv =====
`default_nettype none
// path: an accepted input beat passes the series register stages, the tangent divider and the output register
// throughput: one beat per cycle; the whole pipeline holds while the output stalls
// critical path: one 24x24 multiply per stage in the series terms, one
// compare-subtract per stage in the 40-stage tangent divider
// reset: synchronous active low, clears all valid bits; data registers are not reset
module sine_cosine_tangent_series import scts_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_mode,
    input  wire logic signed [19:0] i_angle,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_saturated
);

    logic en;
    logic [NS:1] r_vld;

    logic signed [ANG_W-1:0] a0, a1, a2, na;
    logic [AX_W-1:0] ax0;

    logic [AX_W-1:0]   r_ax   [1:NS-1];
    logic              r_neg  [1:NS-1];
    logic [1:0]        r_mode [1:NS];
    logic [X2_W-1:0]   r_x2   [2:NS-1];
    logic [TERM_W-1:0] r_f1   [6:NS-1];
    logic [TERM_W-1:0] r_fa   [6:NS-1];
    logic [TERM_W-1:0] r_f2   [9:NS-1];
    logic [TERM_W-1:0] r_fb   [9:NS-1];
    logic signed [SC_W-1:0] r_s, r_c;

    logic [2*AX_W-1:0] sq;
    logic [TERM_W-1:0] t1, ta, t2, tb, t3;
    logic signed [SC_W-1:0] sabs, s_n, c_n, s_mag, c_mag;

    logic [NUM_W-1:0] d_num;
    logic [DEN_W-1:0] d_den;
    t_side            d_side;
    logic             q_valid;
    logic [NUM_W-1:0] q_mag;
    logic [NUM_W-1:0] q_neg;
    t_side            q_side;

    logic signed [VAL_W-1:0] n_value;
    logic                    n_sat;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_sat;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // bring the angle into [-pi, pi)
    always_comb begin
        a0 = {i_angle[19], i_angle};
        a1 = (a0 >= Q_PI) ? a0 - Q_TWO_PI : (a0 < -Q_PI) ? a0 + Q_TWO_PI : a0;
        a2 = (a1 >= Q_PI) ? a1 - Q_TWO_PI : (a1 < -Q_PI) ? a1 + Q_TWO_PI : a1;
        na = -a2;
        ax0 = a2[ANG_W-1] ? na[AX_W-1:0] : a2[AX_W-1:0];
    end

    assign sq = {{AX_W{1'b0}}, r_ax[1]} * {{AX_W{1'b0}}, r_ax[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax[1]   <= ax0;
            r_neg[1]  <= a2[ANG_W-1];
            r_mode[1] <= i_mode;
            for (int k = 2; k <= NS-1; k++) begin
                r_ax[k]  <= r_ax[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            for (int k = 2; k <= NS; k++) begin
                r_mode[k] <= r_mode[k-1];
            end
            r_x2[2] <= sq[X2_W+15:16];
            for (int k = 3; k <= NS-1; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            r_f1[6] <= t1;
            r_fa[6] <= ta;
            for (int k = 7; k <= NS-1; k++) begin
                r_f1[k] <= r_f1[k-1];
                r_fa[k] <= r_fa[k-1];
            end
            r_f2[9] <= t2;
            r_fb[9] <= tb;
            for (int k = 10; k <= NS-1; k++) begin
                r_f2[k] <= r_f2[k-1];
                r_fb[k] <= r_fb[k-1];
            end
            r_s <= s_n;
            r_c <= c_n;
        end
    end

    // sine and cosine terms on |x|, sine sign restored at the end
    scts_term u_sin1 (
        .i_clk(i_clk), .i_en(en), .i_a({{(TERM_W-AX_W){1'b0}}, r_ax[2]}),
        .i_x2(r_x2[2]), .i_recip(RECIP_6), .i_div(DIV_6), .o_f(t1)
    );
    scts_term u_cos1 (
        .i_clk(i_clk), .i_en(en), .i_a({{(TERM_W-X2_W+1){1'b0}}, r_x2[2][X2_W-1:1]}),
        .i_x2(r_x2[2]), .i_recip(RECIP_12), .i_div(DIV_12), .o_f(ta)
    );
    scts_term u_sin2 (
        .i_clk(i_clk), .i_en(en), .i_a(t1),
        .i_x2(r_x2[5]), .i_recip(RECIP_20), .i_div(DIV_20), .o_f(t2)
    );
    scts_term u_cos2 (
        .i_clk(i_clk), .i_en(en), .i_a(ta),
        .i_x2(r_x2[5]), .i_recip(RECIP_30), .i_div(DIV_30), .o_f(tb)
    );
    scts_term u_sin3 (
        .i_clk(i_clk), .i_en(en), .i_a(t2),
        .i_x2(r_x2[8]), .i_recip(RECIP_42), .i_div(DIV_42), .o_f(t3)
    );

    always_comb begin
        sabs = $signed({{(SC_W-AX_W){1'b0}}, r_ax[NS-1]})
             - $signed({1'b0, r_f1[NS-1]})
             + $signed({1'b0, r_f2[NS-1]})
             - $signed({1'b0, t3});
        s_n  = r_neg[NS-1] ? -sabs : sabs;
        c_n  = $signed(SC_W'(65536))
             - $signed({{(SC_W-X2_W+1){1'b0}}, r_x2[NS-1][X2_W-1:1]})
             + $signed({1'b0, r_fa[NS-1]})
             - $signed({1'b0, r_fb[NS-1]});
    end

    always_comb begin
        s_mag = r_s[SC_W-1] ? -r_s : r_s;
        c_mag = r_c[SC_W-1] ? -r_c : r_c;
        d_num = {s_mag[DEN_W-1:0], 16'b0};
        d_den = c_mag[DEN_W-1:0];
        d_side.tan   = r_mode[NS][1];
        d_side.res   = (r_mode[NS] == MODE_COS) ? VAL_W'(r_c) : VAL_W'(r_s);
        d_side.qneg  = r_s[SC_W-1] ^ r_c[SC_W-1];
        d_side.czero = (r_c == '0);
        d_side.sneg  = r_s[SC_W-1];
    end

    scts_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_vld[NS]),
        .i_num(d_num), .i_den(d_den), .i_side(d_side),
        .o_valid(q_valid), .o_quot(q_mag), .o_side(q_side)
    );

    assign q_neg = -q_mag;

    always_comb begin
        n_value = q_side.res;
        n_sat   = 1'b0;
        if (q_side.tan) begin
            if (q_side.czero) begin
                n_sat   = 1'b1;
                n_value = q_side.sneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else if (!q_side.qneg) begin
                if (q_mag > NUM_W'(64'd2147483647)) begin
                    n_sat   = 1'b1;
                    n_value = 32'sh7FFF_FFFF;
                end else begin
                    n_value = q_mag[VAL_W-1:0];
                end
            end else begin
                if (q_mag > NUM_W'(64'd2147483648)) begin
                    n_sat   = 1'b1;
                    n_value = 32'sh8000_0000;
                end else begin
                    n_value = q_neg[VAL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_value <= n_value;
            r_sat   <= n_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

// ===== verif/trig_checker.sv =====
module trig_checker import scts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [1:0]         i_mode,
    input  logic signed [19:0] i_angle,
    input  logic               i_valid_out,
    input  logic               i_stall_out,
    input  logic signed [31:0] i_value,
    input  logic               i_saturated,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q = 65536;
    localparam longint PI_Q = 205887;
    localparam longint TWO_PI_Q = 411775;
    localparam longint TOP = 64'sd2147483647;
    localparam longint BOT = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] value;
        logic               sat;
    } t_trig_result;

    t_trig_result result_q[$];

    function automatic longint fx_mul(longint a, longint b);
        return (a * b) / ONE_Q;
    endfunction

    function automatic longint taylor_sin(longint x);
        longint x2, f, s;
        x2 = fx_mul(x, x);
        f = fx_mul(x, x2) / 6;
        s = x - f;
        f = fx_mul(f, x2) / 20;
        s += f;
        f = fx_mul(f, x2) / 42;
        return s - f;
    endfunction

    function automatic longint taylor_cos(longint x);
        longint x2, f, c;
        x2 = fx_mul(x, x);
        f = x2 / 2;
        c = ONE_Q - f;
        f = fx_mul(f, x2) / 12;
        c += f;
        f = fx_mul(f, x2) / 30;
        return c - f;
    endfunction

    function automatic t_trig_result eval_trig(logic [1:0] mode, logic signed [19:0] ang);
        t_trig_result r;
        longint x, s, c, q;
        x = ang;
        for (int k = 0; k < 2; k++) begin
            if (x >= PI_Q) x -= TWO_PI_Q;
            else if (x < -PI_Q) x += TWO_PI_Q;
        end
        r.sat = 1'b0;
        if (mode[1]) begin
            s = taylor_sin(x);
            c = taylor_cos(x);
            if (c == 0) begin
                r.value = (s >= 0) ? TOP[31:0] : BOT[31:0];
                r.sat = 1'b1;
            end else begin
                q = (s * ONE_Q) / c;
                if (q > TOP) begin
                    q = TOP;
                    r.sat = 1'b1;
                end else if (q < BOT) begin
                    q = BOT;
                    r.sat = 1'b1;
                end
                r.value = q[31:0];
            end
        end else if (mode == MODE_COS) begin
            r.value = 32'(taylor_cos(x));
        end else begin
            r.value = 32'(taylor_sin(x));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_trig_result exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_seen <= 0;
        end else begin
            if (i_valid && !i_stall_in) result_q.push_back(eval_trig(i_mode, i_angle));
            if (i_valid_out && !i_stall_out) begin
                o_seen <= o_seen + 1;
                if (result_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected beat value=%0d", i_value);
                end else begin
                    exp_r = result_q.pop_front();
                    if (exp_r.value !== i_value || exp_r.sat !== i_saturated) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: exp %0d/%0b got %0d/%0b", exp_r.value,
                                     exp_r.sat, i_value, i_saturated);
                    end
                end
            end
        end
        o_pending <= result_q.size();
    end
endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import scts_pkg::*;

    localparam logic [1:0] MODE_SIN = 2'd0;
    localparam logic [1:0] MODE_TAN = 2'd2;
    localparam logic [1:0] MODE_TAN_ALIAS = 2'd3;
    localparam int LIMIT = 400000;

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic [1:0] i_mode = '0;
    logic signed [19:0] i_angle = '0;
    logic o_stall, o_valid, o_saturated;
    logic signed [VAL_W-1:0] o_value;
    int errors, pending, seen, cycles = 0, sent = 0;
    int hold_req = 0;
    logic signed [19:0] edge_angles [13] = '{20'sh7FFFF, -20'sh80000, 20'sd0,
        20'sd205887, -20'sd205887, 20'sd205886, -20'sd205888, 20'sd102943,
        -20'sd102944, 20'sd1, -20'sd1, 20'sd411775, -20'sd411775};

    sine_cosine_tangent_series DUT (.*);

    trig_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_mode, .i_angle,
        .i_valid_out(o_valid), .i_stall_out(i_stall), .i_value(o_value),
        .i_saturated(o_saturated), .o_errors(errors), .o_pending(pending), .o_seen(seen)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stall pattern, with two long holds
    initial begin
        int mode_sel;
        int hold_done;
        mode_sel = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                i_stall <= 1;
                repeat (200) @(posedge i_clk);
            end
            if (cycles % 300 == 0) mode_sel = $urandom_range(0, 2);
            case (mode_sel)
                0: i_stall <= 0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    task automatic send_beat(logic [1:0] mode, logic signed [19:0] ang);
        i_valid <= 1;
        i_mode <= mode;
        i_angle <= ang;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_gap();
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [19:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return 20'($urandom_range(0, 411775) - 205887);
            1: return 20'($urandom());
            2: return 20'(($urandom_range(0, 1) ? 1 : -1)
                          * (int'($urandom_range(0, 2000)) + 102943 - 1000));
            default: return 20'($urandom_range(0, 40) - 20);
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        foreach (edge_angles[k])
            send_beat(MODE_TAN, edge_angles[k]);
        send_beat(MODE_SIN, 20'sh7FFFF);
        send_beat(MODE_COS, -20'sh80000);
        send_beat(MODE_SIN, 20'sd102943);
        send_beat(MODE_COS, 20'sd102943);
        send_beat(MODE_TAN_ALIAS, 20'sd102943);
        send_beat(MODE_TAN_ALIAS, -20'sd300000);
        hold_req++;
        for (int n = 0; n < 1700; n++) begin
            if (n == 300) hold_req++;
            if (n == 900) begin
                i_valid <= 0;
                do @(posedge i_clk); while (pending != 0);
            end
            send_beat(2'($urandom_range(0, 3)), pick_angle());
            if (n % 16 == 0 && n > 0) send_gap();
        end
        i_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (60) @(posedge i_clk);
        $display("covered %0d beats: sine, cosine, tangent and alias mode, wrap edges", sent);
        $display("%0d results checked, %0d mismatches", seen, errors);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
